/* rtl/msva_pkg.sv */
`default_nettype none

package msva_pkg;

    // field and datapath widths
    localparam int CRD_W      = 16;
    localparam int N_COORDS   = 9;
    localparam int COORDS_W   = N_COORDS * CRD_W;
    localparam int OPD_W      = 35;
    localparam int PRD_W      = 2 * OPD_W;
    localparam int TERM_W     = 53;
    localparam int LEN_W      = 68;
    localparam int ROOT_W     = LEN_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int VOL_W      = 64;
    localparam int VOL_OUT_W  = 63;
    localparam int SURF_W     = 48;
    localparam int CNT_W      = 13;
    localparam int IN_W       = 144;
    localparam int OUT_W      = 128;

    // sequencer sizing
    localparam int STEP_W     = 4;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int LOOP_W     = 6;

    typedef enum logic [3:0] {
        OP_AX, OP_AY, OP_AZ,
        OP_UX, OP_UY, OP_UZ,
        OP_VX, OP_VY, OP_VZ,
        OP_EX, OP_EY, OP_EZ
    } op_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_EX,
        DST_EY,
        DST_EZ,
        DST_TERM,
        DST_LEN2
    } dst_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_SQRT,
        SEQ_FINISH
    } seq_op_t;

    typedef struct packed {
        op_sel_t sel_a;
        op_sel_t sel_b;
        acc_op_t acc_op;
        dst_t    dst;
        seq_op_t seq_op;
    } ucw_t;

    typedef struct packed {
        logic busy;
        logic sqrt_en;
        logic finish;
        ucw_t word;
    } seq_ctl_t;

    // microprogram: multiply in step k, accumulate the registered product in
    // step k+1, store the old accumulator value into a destination register
    function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
        ucw_t w;
        case (step)
            0:       w = '{OP_UY, OP_VZ, ACC_HOLD, DST_NONE, SEQ_NEXT};
            1:       w = '{OP_UZ, OP_VY, ACC_LOAD, DST_NONE, SEQ_NEXT};
            2:       w = '{OP_UZ, OP_VX, ACC_SUB,  DST_NONE, SEQ_NEXT};
            3:       w = '{OP_UX, OP_VZ, ACC_LOAD, DST_EX,   SEQ_NEXT};
            4:       w = '{OP_UX, OP_VY, ACC_SUB,  DST_NONE, SEQ_NEXT};
            5:       w = '{OP_UY, OP_VX, ACC_LOAD, DST_EY,   SEQ_NEXT};
            6:       w = '{OP_EX, OP_AX, ACC_SUB,  DST_NONE, SEQ_NEXT};
            7:       w = '{OP_EY, OP_AY, ACC_LOAD, DST_EZ,   SEQ_NEXT};
            8:       w = '{OP_EZ, OP_AZ, ACC_ADD,  DST_NONE, SEQ_NEXT};
            9:       w = '{OP_EX, OP_EX, ACC_ADD,  DST_NONE, SEQ_NEXT};
            10:      w = '{OP_EY, OP_EY, ACC_LOAD, DST_TERM, SEQ_NEXT};
            11:      w = '{OP_EZ, OP_EZ, ACC_ADD,  DST_NONE, SEQ_NEXT};
            12:      w = '{OP_EZ, OP_EZ, ACC_ADD,  DST_NONE, SEQ_NEXT};
            13:      w = '{OP_EZ, OP_EZ, ACC_HOLD, DST_LEN2, SEQ_NEXT};
            14:      w = '{OP_EZ, OP_EZ, ACC_HOLD, DST_NONE, SEQ_SQRT};
            15:      w = '{OP_EZ, OP_EZ, ACC_HOLD, DST_NONE, SEQ_FINISH};
            default: w = '{OP_EZ, OP_EZ, ACC_HOLD, DST_NONE, SEQ_FINISH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/msva_sequencer.sv */
`default_nettype none

module msva_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               finish_ok,
    output msva_pkg::seq_ctl_t ctl
);
    import msva_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [LOOP_W-1:0] loop_reg;
    logic [LOOP_W-1:0] loop_next;
    ucw_t              word;

    always_comb
    begin
        word        = ucode(step_reg);
        ctl.busy    = busy_reg;
        ctl.word    = word;
        ctl.sqrt_en = busy_reg && (word.seq_op == SEQ_SQRT);
        ctl.finish  = busy_reg && (word.seq_op == SEQ_FINISH) && finish_ok;

        busy_next = busy_reg;
        step_next = step_reg;
        loop_next = loop_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
                loop_next = '0;
            end
        end
        else
        begin
            case (word.seq_op)
                SEQ_NEXT:
                begin
                    step_next = STEP_W'(step_reg + 1'b1);
                end
                SEQ_SQRT:
                begin
                    // stay on this step until every root digit is done
                    if (loop_reg == LOOP_W'(SQRT_STEPS - 1))
                    begin
                        step_next = STEP_W'(step_reg + 1'b1);
                        loop_next = '0;
                    end
                    else
                    begin
                        loop_next = LOOP_W'(loop_reg + 1'b1);
                    end
                end
                SEQ_FINISH:
                begin
                    if (finish_ok)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            loop_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            loop_reg <= loop_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/msva_datapath.sv */
`default_nettype none

module msva_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                start,
    input  logic [msva_pkg::COORDS_W-1:0]       coords,
    input  msva_pkg::seq_ctl_t                  ctl,
    output logic signed [msva_pkg::TERM_W-1:0]  term,
    output logic [msva_pkg::ROOT_W-1:0]         area2
);
    import msva_pkg::*;

    localparam int SHIFT = CRD_W - COORD_BITS;

    logic signed [OPD_W-1:0] pt     [N_COORDS];
    logic signed [OPD_W-1:0] a_reg  [3];
    logic signed [OPD_W-1:0] u_reg  [3];
    logic signed [OPD_W-1:0] v_reg  [3];
    logic signed [OPD_W-1:0] e_reg  [3];
    logic signed [OPD_W-1:0] op_a;
    logic signed [OPD_W-1:0] op_b;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [PRD_W-1:0] acc_reg;
    logic signed [PRD_W-1:0] acc_next;
    logic signed [TERM_W-1:0] term_reg;
    logic [LEN_W-1:0]        rad_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [REM_W+1:0]        rem_sh;
    logic [REM_W+1:0]        trial;
    logic [REM_W+1:0]        diff;
    logic                    take;

    // keep the low coordinate bits as a two's complement value
    function automatic logic signed [OPD_W-1:0] sext_coord(input logic [CRD_W-1:0] raw);
        logic signed [CRD_W-1:0] sh;
        sh = $signed(raw << SHIFT) >>> SHIFT;
        return OPD_W'(sh);
    endfunction

    function automatic logic signed [OPD_W-1:0] pick(input op_sel_t sel);
        logic signed [OPD_W-1:0] r;
        case (sel)
            OP_AX:   r = a_reg[0];
            OP_AY:   r = a_reg[1];
            OP_AZ:   r = a_reg[2];
            OP_UX:   r = u_reg[0];
            OP_UY:   r = u_reg[1];
            OP_UZ:   r = u_reg[2];
            OP_VX:   r = v_reg[0];
            OP_VY:   r = v_reg[1];
            OP_VZ:   r = v_reg[2];
            OP_EX:   r = e_reg[0];
            OP_EY:   r = e_reg[1];
            OP_EZ:   r = e_reg[2];
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < N_COORDS; i++)
        begin
            pt[i] = sext_coord(coords[i*CRD_W +: CRD_W]);
        end
        op_a = pick(ctl.word.sel_a);
        op_b = pick(ctl.word.sel_b);

        case (ctl.word.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase

        // one root digit: bring down two radicand bits, try root*4+1
        rem_sh = {rem_reg, rad_reg[LEN_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= pt[k];
                u_reg[k] <= pt[3+k] - pt[k];
                v_reg[k] <= pt[6+k] - pt[k];
            end
        end

        prod_reg <= op_a * op_b;

        if (ctl.busy)
        begin
            acc_reg <= acc_next;
            case (ctl.word.dst)
                DST_EX:   e_reg[0] <= acc_reg[OPD_W-1:0];
                DST_EY:   e_reg[1] <= acc_reg[OPD_W-1:0];
                DST_EZ:   e_reg[2] <= acc_reg[OPD_W-1:0];
                DST_TERM: term_reg <= acc_reg[TERM_W-1:0];
                DST_LEN2:
                begin
                    rad_reg  <= acc_reg[LEN_W-1:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.sqrt_en)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign term  = term_reg;
    assign area2 = root_reg;

endmodule

`default_nettype wire

/* rtl/mesh_volume_surface_accumulator_core.sv */
// one triangle at a time: s_axis_tready stays low while the sequencer runs the
//   microprogram on the one shared multiplier (14 steps) and the 34-step
//   digit-serial square root loop
// a result transfer that is not taken holds a following mesh end in its finish step
// reset: rst_n clears the sequencer, the running mesh sums and flag, and the output valid at once
`default_nettype none

module mesh_volume_surface_accumulator_core #(
    parameter int COORD_BITS    = 16,
    parameter int MAX_TRIANGLES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each), from bit 0 up
    input  logic [msva_pkg::IN_W-1:0]       s_axis_tdata,
    input  logic                            s_axis_tlast,   // last_triangle
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // volume_six_times (63), surface_twice (48), triangle_total (13),
    // saturated (1), zero fill, from bit 0 up
    output logic [msva_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);
    import msva_pkg::*;

    localparam logic signed [VOL_W:0] VOL_HI = {2'b00, {(VOL_W-1){1'b1}}};
    localparam logic signed [VOL_W:0] VOL_LO = -VOL_HI;

    seq_ctl_t                  ctl;
    logic                      start;
    logic                      finish_ok;
    logic signed [TERM_W-1:0]  term;
    logic [ROOT_W-1:0]         area2;

    // per-item flags captured with the input transfer
    logic                      last_reg;
    logic                      skip_reg;

    // running mesh state
    logic signed [VOL_W-1:0]   vol_reg;
    logic signed [VOL_W-1:0]   vol_next;
    logic [SURF_W-1:0]         surf_reg;
    logic [SURF_W-1:0]         surf_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      flag_reg;
    logic                      flag_next;

    // values after this triangle is folded in
    logic signed [VOL_W:0]     vol_sum;
    logic [SURF_W:0]           surf_sum;
    logic signed [VOL_W-1:0]   vol_upd;
    logic [SURF_W-1:0]         surf_upd;
    logic [CNT_W-1:0]          cnt_upd;
    logic                      flag_upd;
    logic signed [VOL_W-1:0]   vol_abs;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [OUT_W-1:0]          out_data_reg;

    assign start         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !ctl.busy;

    // a mesh end may only retire once the result register can take it
    assign finish_ok = !last_reg || !out_valid_reg || m_axis_tready;

    msva_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .finish_ok (finish_ok),
        .ctl       (ctl)
    );

    msva_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .start  (start),
        .coords (s_axis_tdata[COORDS_W-1:0]),
        .ctl    (ctl),
        .term   (term),
        .area2  (area2)
    );

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            last_reg <= s_axis_tlast;
            skip_reg <= (cnt_reg >= CNT_W'(MAX_TRIANGLES));
        end
    end

    always_comb
    begin
        vol_sum  = (VOL_W+1)'(vol_reg) + (VOL_W+1)'(term);
        surf_sum = {1'b0, surf_reg} + (SURF_W+1)'(area2);

        vol_upd  = vol_sum[VOL_W-1:0];
        surf_upd = surf_sum[SURF_W-1:0];
        cnt_upd  = CNT_W'(cnt_reg + 1'b1);
        flag_upd = flag_reg;

        // volume clamps symmetrically so its magnitude fits the result field
        if (vol_sum > VOL_HI)
        begin
            vol_upd  = VOL_HI[VOL_W-1:0];
            flag_upd = 1'b1;
        end
        else if (vol_sum < VOL_LO)
        begin
            vol_upd  = VOL_LO[VOL_W-1:0];
            flag_upd = 1'b1;
        end

        if (surf_sum[SURF_W])
        begin
            surf_upd = '1;
            flag_upd = 1'b1;
        end

        // mesh already full: the triangle is dropped and only flagged
        if (skip_reg)
        begin
            vol_upd  = vol_reg;
            surf_upd = surf_reg;
            cnt_upd  = cnt_reg;
            flag_upd = 1'b1;
        end

        vol_abs = vol_upd[VOL_W-1] ? -vol_upd : vol_upd;

        vol_next       = vol_reg;
        surf_next      = surf_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (ctl.finish)
        begin
            if (last_reg)
            begin
                vol_next       = '0;
                surf_next      = '0;
                cnt_next       = '0;
                flag_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                vol_next  = vol_upd;
                surf_next = surf_upd;
                cnt_next  = cnt_upd;
                flag_next = flag_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg       <= '0;
            surf_reg      <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vol_reg       <= vol_next;
            surf_reg      <= surf_next;
            cnt_reg       <= cnt_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish && last_reg)
        begin
            out_data_reg <= {{(OUT_W - VOL_OUT_W - SURF_W - CNT_W - 1){1'b0}},
                             flag_upd, cnt_upd, surf_upd, vol_abs[VOL_OUT_W-1:0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // after an input transfer the block is busy with that triangle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("input taken while a triangle is in flight");

    // a new result is only loaded when the result register is free
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && last_reg) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    // the volume clamp never reaches the most negative code
    a_vol_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        vol_reg != {1'b1, {(VOL_W-1){1'b0}}})
        else $error("volume sum left the clamp range");

    // triangle count stays within the mesh limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count beyond limit");
`endif

endmodule

`default_nettype wire

/* bench/mesh_totals_checker.sv */
`timescale 1ns / 1ps

module mesh_totals_checker
    import msva_pkg::*;
#(
    parameter int MAX_TRIANGLES = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output int               fail_count,
    output int               pending
);

    localparam int PAD_W = OUT_W - VOL_OUT_W - SURF_W - CNT_W - 1;

    // result word, highest field first
    typedef struct packed {
        logic [PAD_W-1:0]     pad;
        logic                 saturated;
        logic [CNT_W-1:0]     triangle_total;
        logic [SURF_W-1:0]    surface_twice;
        logic [VOL_OUT_W-1:0] volume_six_times;
    } mesh_totals_t;

    localparam longint VOL_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [SURF_W-1:0] SURF_LIMIT = '1;

    // running mesh sums
    longint            vol_acc  = 0;
    logic [SURF_W-1:0] surf_acc = '0;
    int                tri_cnt  = 0;
    logic              sat_flag = 1'b0;
    int                errors   = 0;

    mesh_totals_t expected_totals[$];

    // bit-serial floor square root of the squared edge cross product
    function automatic logic [35:0] twice_area(input logic [71:0] len2);
        logic [35:0] root;
        logic [35:0] trial;
        int          k;
        root = '0;
        for (k = 35; k >= 0; k--) begin
            trial = root | (36'd1 << k);
            if (72'(trial) * 72'(trial) <= len2)
                root = trial;
        end
        return root;
    endfunction

    task automatic fold_triangle(input logic [IN_W-1:0] word, input logic last);
        longint       a [3];
        longint       u [3];
        longint       v [3];
        longint       e [3];
        longint       term;
        logic [63:0]  m;
        logic [71:0]  len2;
        logic [35:0]  area;
        mesh_totals_t t;
        int           k;
        if (tri_cnt >= MAX_TRIANGLES) begin
            sat_flag = 1'b1;
        end else begin
            for (k = 0; k < 3; k++) begin
                a[k] = $signed(word[k*CRD_W +: CRD_W]);
                u[k] = $signed(word[(3+k)*CRD_W +: CRD_W]) - a[k];
                v[k] = $signed(word[(6+k)*CRD_W +: CRD_W]) - a[k];
            end
            e[0] = u[1] * v[2] - u[2] * v[1];
            e[1] = u[2] * v[0] - u[0] * v[2];
            e[2] = u[0] * v[1] - u[1] * v[0];
            term = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
            len2 = '0;
            for (k = 0; k < 3; k++) begin
                m = (e[k] < 0) ? -e[k] : e[k];
                len2 += 72'(m) * 72'(m);
            end
            area = twice_area(len2);

            if (term > 0 && vol_acc > VOL_LIMIT - term) begin
                vol_acc  = VOL_LIMIT;
                sat_flag = 1'b1;
            end else if (term < 0 && vol_acc < -VOL_LIMIT - term) begin
                vol_acc  = -VOL_LIMIT;
                sat_flag = 1'b1;
            end else begin
                vol_acc += term;
            end

            if (SURF_W'(area) > SURF_LIMIT - surf_acc) begin
                surf_acc = SURF_LIMIT;
                sat_flag = 1'b1;
            end else begin
                surf_acc += SURF_W'(area);
            end
            tri_cnt++;
        end

        if (last) begin
            t.pad              = '0;
            t.saturated        = sat_flag;
            t.triangle_total   = CNT_W'(tri_cnt);
            t.surface_twice    = surf_acc;
            t.volume_six_times = VOL_OUT_W'((vol_acc < 0) ? -vol_acc : vol_acc);
            expected_totals.push_back(t);
            vol_acc  = 0;
            surf_acc = '0;
            tri_cnt  = 0;
            sat_flag = 1'b0;
        end
    endtask

    task automatic report_field(input string field, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        mesh_totals_t got;
        mesh_totals_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = mesh_totals_t'(m_axis_tdata);
                if (expected_totals.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_totals.pop_front();
                    report_field("volume_six_times", want.volume_six_times,
                                 got.volume_six_times);
                    report_field("surface_twice", want.surface_twice, got.surface_twice);
                    report_field("triangle_total", want.triangle_total, got.triangle_total);
                    report_field("saturated", want.saturated, got.saturated);
                    report_field("zero fill", want.pad, got.pad);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                fold_triangle(s_axis_tdata, s_axis_tlast);
        end
        fail_count <= errors;
        pending    <= expected_totals.size();
    end

endmodule

/* bench/tb_mesh_volume_surface_accumulator_core.sv */
`timescale 1ns / 1ps

module tb_mesh_volume_surface_accumulator_core
    import msva_pkg::*;
;

    localparam int MAX_TRIANGLES = 4096;
    localparam int RANDOM_ITEMS  = 1170;
    // cycles the result side refuses transfers during the backpressure phase
    localparam int HOLD_CYCLES   = 600;
    // idle time after the last expected result, to watch for stray transfers
    localparam int DRAIN_CYCLES  = 150;

    // how a coordinate is drawn
    typedef enum int {
        STYLE_FULL,     // any 16-bit value
        STYLE_EXTREME,  // range ends and values around zero
        STYLE_NEAR,     // small values, keeps sums readable
        STYLE_FLAT      // all three vertices equal, degenerate facet
    } coord_style_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    wire  [OUT_W-1:0] m_axis_tdata;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;

    int fail_count;
    int pending;

    // handshake between stimulus and the result-side process
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    // suppresses sender gaps for stretches of back-to-back offers
    bit steady_send = 1'b0;
    int burst_left  = 0;

    always #4 clk = ~clk;

    mesh_volume_surface_accumulator_core #(
        .COORD_BITS    (CRD_W),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    mesh_totals_checker #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) i_totals_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // pack vertices a, b, c with a_x in the lowest bits
    function automatic logic [IN_W-1:0] vertices(input int ax, ay, az, bx, by, bz,
                                                 cx, cy, cz);
        return {CRD_W'(cz), CRD_W'(cy), CRD_W'(cx),
                CRD_W'(bz), CRD_W'(by), CRD_W'(bx),
                CRD_W'(az), CRD_W'(ay), CRD_W'(ax)};
    endfunction

    function automatic logic [CRD_W-1:0] pick_coord(input coord_style_t style);
        logic [CRD_W-1:0] c;
        case (style)
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       c = 16'h8000;
                    1:       c = 16'h7FFF;
                    2:       c = 16'h0000;
                    3:       c = 16'hFFFF;
                    default: c = 16'h0001;
                endcase
            end
            STYLE_NEAR: c = CRD_W'($urandom_range(0, 64) - 32);
            default:    c = CRD_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [IN_W-1:0] make_facet(input coord_style_t style);
        logic [IN_W-1:0] word;
        int              k;
        for (k = 0; k < N_COORDS; k++)
            word[k*CRD_W +: CRD_W] = pick_coord(style);
        // flat facet: copy vertex a onto b and c
        if (style == STYLE_FLAT)
        begin
            word[3*CRD_W +: 3*CRD_W] = word[0 +: 3*CRD_W];
            word[6*CRD_W +: 3*CRD_W] = word[0 +: 3*CRD_W];
        end
        return word;
    endfunction

    // offer one facet and hold it until the transfer, then maybe idle
    task automatic send_facet(input logic [IN_W-1:0] word, input logic last);
        int gap;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!steady_send)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                // end of burst: idle short or long so offers land in every
                // phase of the microprogram and the square root loop
                burst_left = $urandom_range(0, 15);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // result side: stall pattern in windows, plus one long hold-off on request
    initial
    begin : result_sink
        int mode;
        int window;
        int held;
        wait (rst_n);
        forever
        begin
            mode   = $urandom_range(0, 2);
            window = $urandom_range(8, 120);
            repeat (window)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    m_axis_tready <= 1'b0;
                    held = 0;
                    while (held < HOLD_CYCLES)
                    begin
                        @(posedge clk);
                        held++;
                    end
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int mesh_len;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero facet as a one-facet mesh
        send_facet(vertices(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        // unit facet then its mirror: volumes cancel, areas add
        send_facet(vertices(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0);
        send_facet(vertices(1, 0, 0, 0, 0, 1, 0, 1, 0), 1'b1);
        // negative orientation alone, result is the magnitude
        send_facet(vertices(1, 0, 0, 0, 0, 1, 0, 1, 0), 1'b1);
        // degenerate: single point, then collinear vertices
        send_facet(vertices(5, -7, 9, 5, -7, 9, 5, -7, 9), 1'b1);
        send_facet(vertices(1, 2, 3, 2, 4, 6, 3, 6, 9), 1'b1);
        // range ends on every coordinate
        send_facet(vertices(-32768, -32768, -32768, 32767, -32768, -32768,
                            -32768, 32767, -32768), 1'b0);
        send_facet(vertices(-32768, -32768, -32768, -32768, 32767, -32768,
                            -32768, -32768, 32767), 1'b0);
        send_facet(vertices(32767, 32767, 32767, -32768, 32767, 32767,
                            32767, -32768, 32767), 1'b1);
        send_facet(vertices(32767, -32768, 32767, -32768, 32767, -32768,
                            32767, 32767, -32768), 1'b1);
        send_facet(vertices(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767), 1'b1);
        // large negative triple product
        send_facet(vertices(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b1);
        for (k = 0; k < 6; k++)
            send_facet(make_facet(STYLE_EXTREME), k == 5);

        // backpressure: one result waits and the next mesh end stalls while one-facet meshes keep coming
        hold_req    = 1'b1;
        steady_send = 1'b1;
        repeat (10) send_facet(make_facet(STYLE_FULL), 1'b1);
        steady_send = 1'b0;

        // random meshes of mostly modest size
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mesh_len    = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
            steady_send = ($urandom_range(0, 7) == 0);
            for (k = 0; k < mesh_len; k++)
                send_facet(make_facet(coord_style_t'($urandom_range(0, 3))),
                           k == mesh_len - 1);
            sent += mesh_len;
        end
        steady_send = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let every mesh result drain, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit, many times the slowest legal run
    initial
    begin : watchdog
        #30ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
